FILE: sv/bitmap_text_blitter_defines.svh
// Assertion macros for the bitmap text blitter.
`ifndef BITMAP_TEXT_BLITTER_DEFINES_SVH
`define BITMAP_TEXT_BLITTER_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define BTB_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define BTB_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/btb_pkg.sv
// Package with types, character codes and the glyph table of the bitmap text blitter.
package btb_pkg;

	// Default page size
	localparam int BTB_PAGE_ROWS = 64;
	localparam int BTB_PAGE_COLS = 64;

	// Width of signed row and column positions during placement
	localparam int POS_W = 12;

	// Character codes
	localparam logic [7:0] CHAR_DOT   = 8'd46;
	localparam logic [7:0] CHAR_STAR  = 8'd42;
	localparam logic [7:0] CHAR_A     = 8'd65;
	localparam logic [7:0] CHAR_Z     = 8'd90;
	localparam logic [7:0] CHAR_SPACE = 8'd32;
	localparam logic [7:0] CHAR_TAB   = 8'd9;
	localparam logic [7:0] CHAR_CR    = 8'd13;
	localparam logic [7:0] CHAR_NUL   = 8'd0;

	// Large font geometry
	localparam int GLYPH_SIZE = 5;
	localparam int GLYPH_ADV  = 6;
	localparam int LETTERS    = 26;
	localparam int GLYPH_BITS = GLYPH_SIZE * GLYPH_SIZE;

	typedef enum logic [1:0] {
		ACT_PLACE  = 2'd0,
		ACT_READ   = 2'd1,
		ACT_CLEAR  = 2'd2,
		ACT_IGNORE = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		JUST_EXPLICIT = 2'd0,
		JUST_LEFT     = 2'd1,
		JUST_RIGHT    = 2'd2,
		JUST_CENTER   = 2'd3
	} justify_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CALC,
		ST_SMALL,
		ST_DRAW,
		ST_READ,
		ST_RESP
	} btb_state_t;

	// One glyph: rows top to bottom, leftmost pixel in the upper bit of each row
	typedef logic [GLYPH_BITS-1:0] glyph_t;

	localparam glyph_t GLYPH_ROM [LETTERS] = '{
		25'b01110_10001_11111_10001_10001, // A
		25'b11110_10001_11110_10001_11110, // B
		25'b01111_10001_10000_10000_01111, // C
		25'b11110_10001_10001_10001_11110, // D
		25'b11111_10000_11100_10000_11111, // E
		25'b11111_10000_11100_10000_10000, // F
		25'b01111_10000_10011_10001_01110, // G
		25'b10001_10001_11111_10001_10001, // H
		25'b11111_00100_00100_00100_11111, // I
		25'b00111_00010_00010_10010_01100, // J
		25'b10001_10010_11100_10010_10001, // K
		25'b10000_10000_10000_10000_11111, // L
		25'b10001_11011_10101_10001_10001, // M
		25'b10001_11001_10101_10011_10001, // N
		25'b01110_10001_10001_10001_01110, // O
		25'b11110_10001_11110_10000_10000, // P
		25'b01110_10001_10001_10011_01111, // Q
		25'b11110_10001_11110_10010_10001, // R
		25'b01111_10000_01110_00001_11110, // S
		25'b11111_10101_00100_00100_01110, // T
		25'b10001_10001_10001_10001_01110, // U
		25'b10001_10001_01010_01010_00100, // V
		25'b10001_10001_10101_11011_10001, // W
		25'b10001_01010_00100_01010_10001, // X
		25'b10001_01010_00100_00100_00100, // Y
		25'b11111_00010_00100_01000_11111  // Z
	};

endpackage

FILE: sv/bitmap_text_blitter.sv
// Bitmap text blitter: character page memory with placement sequencer and read port.
// The page is a PAGE_ROWS x PAGE_COLS byte memory that holds '.' after reset and after a
// clear. All work goes through one memory write port and one cell address unit, one cell
// per cycle, and the input is stalled while an item is in progress. A small-font place
// is setup then its cell write, a large-font letter setup then its 25 glyph pixels, any
// other large-font character setup only, a read a cell read then any wait on the result
// register, and a clear one write per cell. After reset a clearing pass over all
// PAGE_ROWS*PAGE_COLS cells (4096 at the default size) runs before the first item is
// taken. Only reads return a result beat, held in an output register until taken.
`include "bitmap_text_blitter_defines.svh"

module bitmap_text_blitter import btb_pkg::*; #(
	parameter int PAGE_ROWS = BTB_PAGE_ROWS,
	parameter int PAGE_COLS = BTB_PAGE_COLS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        action,
	input  logic              font_large,
	input  logic [1:0]        justify,
	input  logic signed [7:0] row,
	input  logic signed [7:0] column,
	input  logic [5:0]        char_index,
	input  logic [6:0]        string_length,
	input  logic [7:0]        character,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        cell_value
);

	localparam int DEPTH = PAGE_ROWS * PAGE_COLS;
	localparam int AW    = $clog2(DEPTH);
	localparam int RAW   = $clog2(PAGE_ROWS);
	localparam int CAW   = $clog2(PAGE_COLS);
	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
	localparam logic signed [POS_W-1:0] ROWS_S = POS_W'(PAGE_ROWS);
	localparam logic signed [POS_W-1:0] COLS_S = POS_W'(PAGE_COLS);
	localparam logic signed [POS_W-1:0] HALF_COLS_S = POS_W'(PAGE_COLS / 2);
	localparam logic [2:0] GLYPH_LAST = 3'(GLYPH_SIZE - 1);

	btb_state_t state_q, state_d;

	// Captured item fields
	logic              font_large_q;
	justify_t          justify_q;
	logic signed [7:0] row_q;
	logic signed [7:0] column_q;
	logic [5:0]        char_index_q;
	logic [6:0]        string_length_q;
	logic [7:0]        character_q;

	// Placement state
	logic signed [POS_W-1:0] r_q;
	logic signed [POS_W-1:0] j_q;
	logic                    s_neg_q;
	glyph_t                  glyph_q;
	logic [2:0]              f_q;
	logic [2:0]              g_q;
	logic [AW-1:0]           clr_addr_q;

	// Read path
	logic [7:0] rd_data_q;
	logic       rd_hit_q;
	logic       out_valid_q;
	logic [7:0] cell_value_q;

	// Combinational signals
	logic                    in_accept;
	logic                    draw_last;
	logic                    resp_load;
	logic                    is_letter_c;
	logic                    is_space_c;
	logic [4:0]              letter_c;
	logic signed [POS_W-1:0] wlen_c;
	logic signed [POS_W-1:0] step_c;
	logic signed [POS_W-1:0] s_c;
	logic signed [POS_W-1:0] cell_row_c;
	logic signed [POS_W-1:0] cell_col_c;
	logic                    in_page_c;
	logic [AW-1:0]           addr_c;
	logic                    mem_we;
	logic [AW-1:0]           mem_waddr;
	logic [7:0]              mem_wdata;

	logic [7:0] page_mem [DEPTH];

	assign in_accept = in_valid && !in_stall;
	assign draw_last = (f_q == GLYPH_LAST) && (g_q == GLYPH_LAST);
	assign resp_load = (state_q == ST_RESP) && (!out_valid_q || !out_stall);

	// Classify the held character
	assign is_letter_c = (character_q >= CHAR_A) && (character_q <= CHAR_Z);
	assign is_space_c  = (character_q == CHAR_SPACE)
		|| ((character_q >= CHAR_TAB) && (character_q <= CHAR_CR));
	assign letter_c    = 5'(character_q - CHAR_A);

	// Work out the string start column and this character's first column
	always_comb begin
		wlen_c = font_large_q ? POS_W'(string_length_q) * POS_W'(GLYPH_ADV)
			: POS_W'(string_length_q);
		step_c = font_large_q ? POS_W'(char_index_q) * POS_W'(GLYPH_ADV)
			: POS_W'(char_index_q);
		unique case (justify_q)
			JUST_EXPLICIT: s_c = POS_W'(column_q) - POS_W'(1);
			JUST_LEFT:     s_c = '0;
			JUST_RIGHT:    s_c = COLS_S - wlen_c;
			JUST_CENTER:   s_c = HALF_COLS_S - (wlen_c >>> 1);
			default:       s_c = '0;
		endcase
	end

	// Select the cell that the shared address unit works on
	always_comb begin
		unique case (state_q)
			ST_READ: begin
				cell_row_c = POS_W'(row_q);
				cell_col_c = POS_W'(column_q);
			end
			ST_DRAW: begin
				cell_row_c = r_q + POS_W'(f_q);
				cell_col_c = j_q + POS_W'(g_q);
			end
			default: begin
				cell_row_c = r_q;
				cell_col_c = j_q;
			end
		endcase
	end

	// Clip to the page and form the linear cell address
	assign in_page_c = !cell_row_c[POS_W-1] && (cell_row_c < ROWS_S)
		&& !cell_col_c[POS_W-1] && (cell_col_c < COLS_S);
	assign addr_c = in_page_c
		? AW'(cell_row_c[RAW-1:0] * PAGE_COLS) + AW'(cell_col_c[CAW-1:0]) : '0;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_addr_q == LAST_ADDR) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					unique case (action_t'(action))
						ACT_PLACE:  state_d = ST_CALC;
						ACT_READ:   state_d = ST_READ;
						ACT_CLEAR:  state_d = ST_CLEAR;
						ACT_IGNORE: state_d = ST_IDLE;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_CALC: begin
				priority if (!font_large_q) state_d = ST_SMALL;
				else if (is_letter_c)       state_d = ST_DRAW;
				else                        state_d = ST_IDLE;
			end
			ST_SMALL: state_d = ST_IDLE;
			ST_DRAW: begin
				if (draw_last) state_d = ST_IDLE;
			end
			ST_READ: state_d = ST_RESP;
			ST_RESP: begin
				if (resp_load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: stall and memory write port
	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		mem_we    = 1'b0;
		mem_waddr = addr_c;
		mem_wdata = character_q;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_addr_q;
				mem_wdata = CHAR_DOT;
			end
			ST_SMALL: begin
				mem_we = in_page_c && !s_neg_q && (character_q != CHAR_NUL) && !is_space_c;
			end
			ST_DRAW: begin
				mem_we    = in_page_c && !r_q[POS_W-1] && glyph_q[GLYPH_BITS-1];
				mem_wdata = CHAR_STAR;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			f_q         <= '0;
			g_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// Sweep the page while clearing, restart on a clear beat
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end else if (in_accept && (action_t'(action) == ACT_CLEAR)) begin
				clr_addr_q <= '0;
			end
			// Advance through the glyph pixels row by row
			if (state_q == ST_CALC) begin
				f_q <= '0;
				g_q <= '0;
			end else if (state_q == ST_DRAW) begin
				if (g_q == GLYPH_LAST) begin
					g_q <= '0;
					f_q <= f_q + 3'd1;
				end else begin
					g_q <= g_q + 3'd1;
				end
			end
			// Hold the result beat until taken
			if (resp_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_accept) begin
			font_large_q    <= font_large;
			justify_q       <= justify_t'(justify);
			row_q           <= row;
			column_q        <= column;
			char_index_q    <= char_index;
			string_length_q <= string_length;
			character_q     <= character;
		end
		if (state_q == ST_CALC) begin
			r_q     <= POS_W'(row_q) - POS_W'(1);
			j_q     <= s_c + step_c;
			s_neg_q <= s_c[POS_W-1];
			glyph_q <= is_letter_c ? GLYPH_ROM[letter_c] : '0;
		end else if (state_q == ST_DRAW) begin
			glyph_q <= glyph_q << 1;
		end
		if (state_q == ST_READ) begin
			rd_hit_q <= in_page_c;
		end
		if (resp_load) begin
			cell_value_q <= rd_hit_q ? rd_data_q : 8'd0;
		end
	end

	// Page memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			page_mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			rd_data_q <= page_mem[addr_c];
		end
	end

	assign out_valid  = out_valid_q;
	assign cell_value = cell_value_q;

	// Checks on the sequencer
	`BTB_ASSERT_IMP(a_we_state, mem_we, (state_q == ST_CLEAR) || (state_q == ST_SMALL) || (state_q == ST_DRAW), "page write outside a write state")
	`BTB_ASSERT_IMP(a_draw_star, mem_we && (state_q == ST_DRAW), mem_wdata == CHAR_STAR, "glyph pixel not written as star")
	`BTB_ASSERT_NXT(a_clear_end, (state_q == ST_CLEAR) && (clr_addr_q == LAST_ADDR), state_q == ST_IDLE, "clear pass did not end at last cell")
	`BTB_ASSERT_NXT(a_draw_end, (state_q == ST_DRAW) && draw_last, state_q == ST_IDLE, "glyph draw ran past last pixel")
	`BTB_ASSERT_NXT(a_busy, in_accept && (action_t'(action) != ACT_IGNORE), in_stall, "accepted beat did not start work")

endmodule
